/* rtl/fsr_baw_pkg.sv */
package fsr_baw_pkg;

    // Samples summed into one block.
    localparam int BLOCK_SIZE = 2048;

    // The count runs 0 .. BLOCK_SIZE-1, and the sum holds BLOCK_SIZE full-scale samples.
    localparam int SAMPLE_W = 16;
    localparam int CNT_W    = $clog2(BLOCK_SIZE);
    localparam int SUM_W    = SAMPLE_W + CNT_W;

    localparam int OHMS_W   = 20;
    localparam int COEF_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // Conductance divider: a 36-bit denominator (mean times series ohms)
    // and a 32-bit quotient.
    localparam int DEN_W    = 36;
    localparam int QUO_W    = 32;
    localparam int STEP_W   = 5;
    localparam int MEAN_STEPS = 16;
    localparam int COND_STEPS = 32;

    // 1000 * (65536 - mean) fits in 26 bits.
    localparam int PROD_W   = 26;
    localparam int DIFF_W   = 17;
    localparam logic [DIFF_W-1:0] FULL_SCALE = 17'h1_0000;
    localparam logic [PROD_W-1:0] MILLI      = 26'd1000;

    // Polynomial accumulator: five 32-bit limbs in two's complement.
    localparam int LIMB_W   = 32;
    localparam int LIMBS    = 5;
    localparam int ACC_W    = LIMB_W * LIMBS;
    localparam int LIMB_IDX_W = 3;
    localparam int PASS_W   = 2;
    localparam logic [PASS_W-1:0] PASS_ROUND = 2'd3;
    localparam logic [LIMB_W-1:0] TENTHS     = 32'd10;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_SERIES_OHMS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ZERO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ONE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_TWO    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_THREE  = 3'd4;

    // Register values after reset.
    localparam logic [OHMS_W-1:0]        RST_SERIES_OHMS = 20'd10000;
    localparam logic signed [COEF_W-1:0] RST_COEF_ZERO   = -32'sd8755;
    localparam logic signed [COEF_W-1:0] RST_COEF_ONE    = 32'sd514048;
    localparam logic signed [COEF_W-1:0] RST_COEF_TWO    = -32'sd695040;
    localparam logic signed [COEF_W-1:0] RST_COEF_THREE  = 32'sd1832704;

endpackage

/* rtl/fsr_block_average_weight.sv */
// Force-sensor weigh block.
// Input channel: i_valid / o_stall carry one 16-bit converter sample per beat
// on i_sample. Samples are summed in blocks of BLOCK_SIZE (package constant).
// Output channel: o_valid / i_stall carry one result beat per block:
// o_mean_code, o_weight_tenths and o_saturated.
// Configuration: a write on i_cfg_we with i_cfg_index and i_cfg_data sets the
// series resistor or a cubic coefficient; unknown indexes are dropped. Write
// only while the block is idle.
// Throughput: a sample is taken every cycle, except after the last sample of
// a block. That sample starts a serial computation: the restoring division
// that forms the mean, the denominator product and range check, the
// bit-serial conductance division (skipped when the conductance saturates),
// and four limb-serial passes through one 32x32 multiplier (three Horner
// steps and the rounding step). The result is then loaded into the output
// register once that is free; o_stall is high for all of that time. A stalled
// result stays in the output register while sampling goes on; a finished
// block then waits with o_stall high until the output register is free.
// Reset (synchronous, active low) clears the sum, the count and the output
// valid flag and reloads the register reset values.
module fsr_block_average_weight
    import fsr_baw_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [SAMPLE_W-1:0]          i_sample,

    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [SAMPLE_W-1:0]          o_mean_code,
    output logic signed [COEF_W-1:0]     o_weight_tenths,
    output logic                         o_saturated,

    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEAN,
        ST_PROD,
        ST_CHECK,
        ST_COND,
        ST_POLY,
        ST_DONE
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [OHMS_W-1:0]        r_series_ohms;
    logic signed [COEF_W-1:0] r_coef_zero;
    logic signed [COEF_W-1:0] r_coef_one;
    logic signed [COEF_W-1:0] r_coef_two;
    logic signed [COEF_W-1:0] r_coef_three;

    // Block accumulation.
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_count;
    logic [SUM_W-1:0] n_sum;
    logic             w_in_take;
    logic             w_last;

    // Shared restoring divider: remainder, denominator, dividend bits still
    // to come (MSB first) and the quotient as it shifts in.
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [QUO_W-1:0]  r_dlow;
    logic [QUO_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_step;
    logic [DEN_W:0]    w_trial;
    logic              w_ge;
    logic [DEN_W:0]    w_diff;

    logic [PROD_W-1:0]   r_prod;
    logic [SAMPLE_W-1:0] r_mean;
    logic [DIFF_W-1:0]   w_span;
    logic                w_cond_sat;

    // Limb-serial polynomial unit.
    logic [ACC_W-1:0]      r_acc;
    logic [LIMB_W-1:0]     r_carry;
    logic [LIMB_IDX_W-1:0] r_limb;
    logic [PASS_W-1:0]     r_pass;
    logic                  r_neg;
    logic                  r_sat;
    logic [ACC_W-1:0]      w_term;
    logic [LIMB_W-1:0]     w_term_limb;
    logic [LIMB_W-1:0]     w_op;
    logic [LIMB_W-1:0]     w_mult;
    logic [2*LIMB_W-1:0]   w_t;

    // Final rounding and clamping.
    logic                     w_big;
    logic [LIMB_W-1:0]        w_mag;
    logic [COEF_W-1:0]        w_weight;
    logic                     w_wsat;

    logic r_o_valid;
    logic [SAMPLE_W-1:0]      r_o_mean;
    logic [COEF_W-1:0]        r_o_weight;
    logic                     r_o_sat;
    logic                     w_out_free;

    assign o_stall   = (r_state != ST_IDLE);
    assign w_in_take = i_valid && (r_state == ST_IDLE);
    assign w_last    = (r_count == CNT_W'(BLOCK_SIZE - 1));
    assign n_sum     = r_sum + SUM_W'(i_sample);

    assign w_out_free = !r_o_valid || !i_stall;

    // One restoring step: bring down the next dividend bit and subtract if it fits.
    assign w_trial = {r_rem, r_dlow[QUO_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    assign w_span = FULL_SCALE - DIFF_W'(r_mean);

    // The quotient overflows Q8.24 when the high 32-bit-shifted part of the
    // dividend already reaches the denominator.
    assign w_cond_sat = (r_den == '0) || (DEN_W'(r_prod[PROD_W-1:8]) >= r_den);

    // Term that each pass adds: the next coefficient at its Horner weight, or
    // in the rounding pass one half of the output step (plus ten when the
    // value is negated, completing the two's complement of ~p * 10).
    always_comb begin
        case (r_pass)
            2'd0:    w_term = {{(ACC_W-COEF_W){r_coef_two[COEF_W-1]}}, r_coef_two} << 24;
            2'd1:    w_term = {{(ACC_W-COEF_W){r_coef_one[COEF_W-1]}}, r_coef_one} << 48;
            2'd2:    w_term = {{(ACC_W-COEF_W){r_coef_zero[COEF_W-1]}}, r_coef_zero} << 72;
            default: w_term = (ACC_W'(1) << 79) | (r_neg ? ACC_W'(TENTHS) : '0);
        endcase
    end

    assign w_term_limb = w_term[{r_limb, 5'b0} +: LIMB_W];
    assign w_op   = (r_pass == PASS_ROUND && r_neg) ? ~r_acc[LIMB_W-1:0] : r_acc[LIMB_W-1:0];
    assign w_mult = (r_pass == PASS_ROUND) ? TENTHS : r_quo;
    assign w_t    = 64'(w_op) * 64'(w_mult) + 64'(r_carry) + 64'(w_term_limb);

    // After the rounding pass the accumulator holds |p| * 10 + 2^79; the
    // weight in tenths sits at bit 80.
    always_comb begin
        w_big = |r_acc[ACC_W-1:112];
        w_mag = r_acc[111:80];
        if (!r_neg) begin
            w_wsat   = w_big || w_mag[LIMB_W-1];
            w_weight = w_wsat ? 32'h7FFF_FFFF : w_mag;
        end else begin
            w_wsat   = w_big || (w_mag > 32'h8000_0000);
            w_weight = w_wsat ? 32'h8000_0000 : (32'd0 - w_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_sum         <= '0;
            r_count       <= '0;
            r_o_valid     <= 1'b0;
            r_series_ohms <= RST_SERIES_OHMS;
            r_coef_zero   <= RST_COEF_ZERO;
            r_coef_one    <= RST_COEF_ONE;
            r_coef_two    <= RST_COEF_TWO;
            r_coef_three  <= RST_COEF_THREE;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SERIES_OHMS: r_series_ohms <= i_cfg_data[OHMS_W-1:0];
                    REG_COEF_ZERO:   r_coef_zero   <= $signed(i_cfg_data);
                    REG_COEF_ONE:    r_coef_one    <= $signed(i_cfg_data);
                    REG_COEF_TWO:    r_coef_two    <= $signed(i_cfg_data);
                    REG_COEF_THREE:  r_coef_three  <= $signed(i_cfg_data);
                    default: ;
                endcase
            end

            // In ST_DONE the output register is reloaded below instead.
            if (r_o_valid && !i_stall && r_state != ST_DONE) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_in_take) begin
                        if (w_last) begin
                            r_sum   <= '0;
                            r_count <= '0;
                            // The quotient of sum / BLOCK_SIZE is below 2^16,
                            // so the high part starts as the remainder.
                            r_rem   <= DEN_W'(n_sum[SUM_W-1:SAMPLE_W]);
                            r_dlow  <= {n_sum[SAMPLE_W-1:0], {(QUO_W-SAMPLE_W){1'b0}}};
                            r_den   <= DEN_W'(BLOCK_SIZE);
                            r_step  <= '0;
                            r_sat   <= 1'b0;
                            r_state <= ST_MEAN;
                        end else begin
                            r_sum   <= n_sum;
                            r_count <= r_count + 1'b1;
                        end
                    end
                end

                ST_MEAN, ST_COND: begin
                    r_rem  <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                    r_quo  <= {r_quo[QUO_W-2:0], w_ge};
                    r_dlow <= r_dlow << 1;
                    r_step <= r_step + 1'b1;
                    if (r_state == ST_MEAN && r_step == STEP_W'(MEAN_STEPS - 1)) begin
                        r_state <= ST_PROD;
                    end
                    if (r_state == ST_COND && r_step == STEP_W'(COND_STEPS - 1)) begin
                        r_acc   <= {{(ACC_W-COEF_W){r_coef_three[COEF_W-1]}}, r_coef_three};
                        r_carry <= '0;
                        r_limb  <= '0;
                        r_pass  <= '0;
                        r_state <= ST_POLY;
                    end
                end

                ST_PROD: begin
                    r_mean  <= r_quo[SAMPLE_W-1:0];
                    r_den   <= DEN_W'(r_quo[SAMPLE_W-1:0]) * DEN_W'(r_series_ohms);
                    r_state <= ST_CHECK;
                end

                ST_CHECK: begin
                    if (w_cond_sat) begin
                        r_quo   <= '1;
                        r_sat   <= 1'b1;
                        r_acc   <= {{(ACC_W-COEF_W){r_coef_three[COEF_W-1]}}, r_coef_three};
                        r_carry <= '0;
                        r_limb  <= '0;
                        r_pass  <= '0;
                        r_state <= ST_POLY;
                    end else begin
                        r_rem   <= DEN_W'(r_prod[PROD_W-1:8]);
                        r_dlow  <= {r_prod[7:0], {(QUO_W-8){1'b0}}};
                        r_step  <= '0;
                        r_state <= ST_COND;
                    end
                end

                ST_POLY: begin
                    // Low limb out, new limb in at the top.
                    r_acc <= {w_t[LIMB_W-1:0], r_acc[ACC_W-1:LIMB_W]};
                    if (r_limb == LIMB_IDX_W'(LIMBS - 1)) begin
                        r_limb  <= '0;
                        r_carry <= '0;
                        r_pass  <= r_pass + 1'b1;
                        if (r_pass == 2'd2) begin
                            r_neg <= w_t[LIMB_W-1];
                        end
                        if (r_pass == PASS_ROUND) begin
                            r_state <= ST_DONE;
                        end
                    end else begin
                        r_limb  <= r_limb + 1'b1;
                        r_carry <= w_t[2*LIMB_W-1:LIMB_W];
                    end
                end

                ST_DONE: begin
                    if (w_out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_mean   <= r_mean;
                        r_o_weight <= w_weight;
                        r_o_sat    <= r_sat || w_wsat;
                        r_state    <= ST_IDLE;
                    end
                end

                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Constant product for the conductance numerator; registered on its own.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_PROD) begin
            r_prod <= PROD_W'(r_quo[SAMPLE_W-1:0] == '0 ? FULL_SCALE :
                              FULL_SCALE - DIFF_W'(r_quo[SAMPLE_W-1:0])) * MILLI;
        end else if (r_state == ST_CHECK) begin
            r_prod <= PROD_W'(w_span) * MILLI;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_mean_code     = r_o_mean;
    assign o_weight_tenths = $signed(r_o_weight);
    assign o_saturated     = r_o_sat;

endmodule

/* dv/fsr_baw_checker.sv */
module fsr_baw_checker
    import fsr_baw_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_smp_valid,
    input  logic                     i_smp_stall,
    input  logic [SAMPLE_W-1:0]      i_sample,

    input  logic                     i_res_valid,
    input  logic                     i_res_stall,
    input  logic [SAMPLE_W-1:0]      i_mean_code,
    input  logic signed [COEF_W-1:0] i_weight_tenths,
    input  logic                     i_saturated,

    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,

    output int                       o_fail_count,
    output int                       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POLY_W      = 192;
    localparam int G_FRAC      = 24;
    // Weight units are 1/256 gram, so tenths sit 8 bits above the Horner scale.
    localparam int TENTHS_SHIFT = 3 * G_FRAC + 8;
    localparam logic [COEF_W-1:0] WEIGHT_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0] WEIGHT_NEG_MAX = 32'h8000_0000;

    typedef struct packed {
        logic [SAMPLE_W-1:0]      mean;
        logic signed [COEF_W-1:0] weight;
        logic                     sat;
    } t_weighing;

    t_weighing pending_weighings[$];

    logic [OHMS_W-1:0]        series_ohms;
    logic signed [COEF_W-1:0] coef0, coef1, coef2, coef3;
    logic [SUM_W-1:0]         block_total;
    int unsigned              block_count;
    int                       fail_count = 0;
    int                       result_index = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        fail_count++;
    endtask

    // Mean, conductance in Q8.24 and cubic weight, computed exactly.
    function automatic t_weighing predict_weighing(input logic [SUM_W-1:0] total);
        t_weighing            r;
        logic [63:0]          den, num, quo;
        logic [31:0]          g;
        logic signed [POLY_W-1:0] p, term, gw;
        logic [POLY_W-1:0]    mag, rounded;
        logic                 neg, big;
        r.sat  = 1'b0;
        r.mean = SAMPLE_W'(total / BLOCK_SIZE);
        den = 64'(r.mean) * 64'(series_ohms);
        if (den == 64'd0) begin
            g = '1;
            r.sat = 1'b1;
        end else begin
            num = (64'(MILLI) * (64'(FULL_SCALE) - 64'(r.mean))) << G_FRAC;
            quo = num / den;
            if (quo > 64'hFFFF_FFFF) begin
                g = '1;
                r.sat = 1'b1;
            end else begin
                g = quo[31:0];
            end
        end

        gw   = $signed({160'd0, g});
        p    = coef3;
        p    = p * gw;
        term = coef2;
        p    = p + (term <<< G_FRAC);
        p    = p * gw;
        term = coef1;
        p    = p + (term <<< (2 * G_FRAC));
        p    = p * gw;
        term = coef0;
        p    = p + (term <<< (3 * G_FRAC));

        // Round the magnitude half away from zero, then restore the sign.
        neg = p[POLY_W-1];
        mag = neg ? -p : p;
        rounded = (mag * POLY_W'(TENTHS) + (POLY_W'(1) << (TENTHS_SHIFT - 1)))
                  >> TENTHS_SHIFT;
        big = |rounded[POLY_W-1:32];
        if (!neg) begin
            if (big || rounded[31:0] > WEIGHT_POS_MAX) begin
                r.weight = WEIGHT_POS_MAX;
                r.sat = 1'b1;
            end else begin
                r.weight = rounded[31:0];
            end
        end else if (big || rounded[31:0] > WEIGHT_NEG_MAX) begin
            r.weight = WEIGHT_NEG_MAX;
            r.sat = 1'b1;
        end else begin
            r.weight = -rounded[31:0];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_weighing want;
        if (!i_rst_n) begin
            series_ohms = RST_SERIES_OHMS;
            coef0 = RST_COEF_ZERO;
            coef1 = RST_COEF_ONE;
            coef2 = RST_COEF_TWO;
            coef3 = RST_COEF_THREE;
            block_total = '0;
            block_count = 0;
            pending_weighings.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SERIES_OHMS: series_ohms = i_cfg_data[OHMS_W-1:0];
                    REG_COEF_ZERO:   coef0 = i_cfg_data;
                    REG_COEF_ONE:    coef1 = i_cfg_data;
                    REG_COEF_TWO:    coef2 = i_cfg_data;
                    REG_COEF_THREE:  coef3 = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_res_valid && !i_res_stall) begin
                if (pending_weighings.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              result_index));
                end else begin
                    want = pending_weighings.pop_front();
                    if (i_mean_code !== want.mean)
                        report_mismatch($sformatf("result %0d mean_code %0d, expected %0d",
                                                  result_index, i_mean_code, want.mean));
                    if (i_weight_tenths !== want.weight)
                        report_mismatch($sformatf("result %0d weight_tenths %0d, expected %0d",
                                                  result_index, i_weight_tenths, want.weight));
                    if (i_saturated !== want.sat)
                        report_mismatch($sformatf("result %0d saturated %0b, expected %0b",
                                                  result_index, i_saturated, want.sat));
                end
                result_index++;
            end

            if (i_smp_valid && !i_smp_stall) begin
                block_total = block_total + SUM_W'(i_sample);
                block_count++;
                if (block_count == BLOCK_SIZE) begin
                    pending_weighings.push_back(predict_weighing(block_total));
                    block_total = '0;
                    block_count = 0;
                end
            end
        end
        o_pending <= pending_weighings.size();
    end

endmodule

/* dv/fsr_block_average_weight_tb.sv */
module fsr_block_average_weight_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fsr_baw_pkg::*;

    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;

    // Random phases after the directed part; each phase runs a few whole blocks so
    // that every phase ends at a block boundary and the block is idle afterwards.
    localparam int RANDOM_PHASES    = 12;
    localparam int BLOCKS_PER_PHASE = 3;

    // The block needs time to compute after the last sample of a block; this
    // pause covers that with margin before any register write.
    localparam int DRAIN_CYCLES = 100;

    // Long receiver hold-off: long enough for one result to sit in the output
    // register, the next block to finish behind it and the input to back up.
    localparam int HOLD_CYCLES = 9000;

    // 46 blocks of 2048 samples. Worst case every sample waits out the longest
    // random gap, plus the hold-off and the drain pauses; taken about three
    // times over.
    localparam int unsigned CYCLE_LIMIT = 3_500_000;

    typedef enum int {
        SHAPE_FLAT,
        SHAPE_ALTERNATE,
        SHAPE_JITTER,
        SHAPE_UNIFORM
    } t_block_shape;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic [SAMPLE_W-1:0]      i_sample = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic [SAMPLE_W-1:0]      o_mean_code;
    logic signed [COEF_W-1:0] o_weight_tenths;
    logic                     o_saturated;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;

    int          fail_count;
    int          pending_count;
    int unsigned cycle_count = 0;

    // Shared control between the sample driver and the result receiver.
    bit idle_on = 1'b1;
    bit pressure_go = 1'b0;
    bit pressure_done = 1'b0;
    int hold_left = 0;
    int stall_left = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    fsr_block_average_weight i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_sample        (i_sample),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_mean_code     (o_mean_code),
        .o_weight_tenths (o_weight_tenths),
        .o_saturated     (o_saturated),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    fsr_baw_checker u_weigh_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_smp_valid     (i_valid),
        .i_smp_stall     (o_stall),
        .i_sample        (i_sample),
        .i_res_valid     (o_valid),
        .i_res_stall     (i_stall),
        .i_mean_code     (o_mean_code),
        .i_weight_tenths (o_weight_tenths),
        .i_saturated     (o_saturated),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending_count)
    );

    // Result receiver. A requested hold-off keeps stall high for a long run of
    // cycles; otherwise stall comes in short random bursts while idling is on.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else if (pressure_go && !pressure_done) begin
            pressure_done <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 11) == 0) begin
            stall_left <= $urandom_range(0, 9);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // A hung block or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Drops valid, waits until every expected result has been taken, then lets
    // the block's latency pass so that it is surely idle.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Sends one whole block of samples. Each beat may be preceded by a short
    // gap with valid low; otherwise valid stays high from beat to beat.
    task automatic send_block(input t_block_shape shape, input int center,
                              input int spread);
        int value;
        int gap;
        for (int n = 0; n < BLOCK_SIZE; n++) begin
            case (shape)
                SHAPE_FLAT:      value = center;
                SHAPE_ALTERNATE: value = n[0] ? SAMPLE_MAX : 0;
                SHAPE_JITTER: begin
                    value = center + int'($urandom_range(0, 2 * spread)) - spread;
                    if (value < 0)
                        value = 0;
                    else if (value > SAMPLE_MAX)
                        value = SAMPLE_MAX;
                end
                default:         value = $urandom_range(0, SAMPLE_MAX);
            endcase
            if (idle_on && $urandom_range(0, 15) == 0) begin
                gap = $urandom_range(1, 10);
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid  <= 1'b1;
            i_sample <= SAMPLE_W'(value);
            @(posedge i_clk);
            while (o_stall)
                @(posedge i_clk);
        end
    endtask

    initial begin
        int center;
        int pick;
        logic [CFG_DATA_W-1:0] coef;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset registers first. An all-zero block gives a mean
        // of zero, which saturates the conductance. Full scale gives the
        // smallest conductance, and alternating extremes a mean that truncates.
        send_block(SHAPE_FLAT, 0, 0);
        send_block(SHAPE_FLAT, SAMPLE_MAX, 0);
        send_block(SHAPE_ALTERNATE, 0, 0);

        // Smallest resistor with a mean of one drives the conductance past
        // Q8.24, and the largest coefficients push the weight over the top.
        settle();
        write_reg(REG_SERIES_OHMS, CFG_DATA_W'(1));
        write_reg(REG_COEF_ZERO, 32'h7FFF_FFFF);
        write_reg(REG_COEF_ONE, 32'h7FFF_FFFF);
        write_reg(REG_COEF_TWO, 32'h7FFF_FFFF);
        write_reg(REG_COEF_THREE, 32'h7FFF_FFFF);
        send_block(SHAPE_FLAT, 1, 0);
        send_block(SHAPE_FLAT, SAMPLE_MAX, 0);

        // Largest resistor field and the most negative coefficients: the weight
        // clamps at the negative end.
        settle();
        write_reg(REG_SERIES_OHMS, {12'hFFF, {OHMS_W{1'b1}}});
        write_reg(REG_COEF_ZERO, 32'h8000_0000);
        write_reg(REG_COEF_ONE, 32'h8000_0000);
        write_reg(REG_COEF_TWO, 32'h8000_0000);
        write_reg(REG_COEF_THREE, 32'h8000_0000);
        send_block(SHAPE_FLAT, 1, 0);

        // A zero resistor behaves like a mean of zero.
        settle();
        write_reg(REG_SERIES_OHMS, CFG_DATA_W'(0));
        send_block(SHAPE_JITTER, 20000, 500);

        // Constant-only polynomial: 64/256 g is exactly 2.5 tenths, so these
        // two blocks land on rounding ties of both signs.
        settle();
        write_reg(REG_SERIES_OHMS, CFG_DATA_W'(RST_SERIES_OHMS));
        write_reg(REG_COEF_ONE, '0);
        write_reg(REG_COEF_TWO, '0);
        write_reg(REG_COEF_THREE, '0);
        write_reg(REG_COEF_ZERO, CFG_DATA_W'(64));
        send_block(SHAPE_FLAT, 32768, 0);
        settle();
        write_reg(REG_COEF_ZERO, -CFG_DATA_W'(64));
        send_block(SHAPE_FLAT, 32768, 0);

        // Back to the reset registers, then writes to unused indexes, which must
        // change nothing, before a plain jittered block.
        settle();
        write_reg(REG_COEF_ZERO, CFG_DATA_W'(RST_COEF_ZERO));
        write_reg(REG_COEF_ONE, CFG_DATA_W'(RST_COEF_ONE));
        write_reg(REG_COEF_TWO, CFG_DATA_W'(RST_COEF_TWO));
        write_reg(REG_COEF_THREE, CFG_DATA_W'(RST_COEF_THREE));
        for (int idx = int'(REG_COEF_THREE) + 1; idx < (1 << CFG_IDX_W); idx++)
            write_reg(CFG_IDX_W'(idx), $urandom);
        send_block(SHAPE_JITTER, 3000, 200);

        // Random phases: new registers each phase, then whole blocks with
        // mostly jittered means spread over the full range, weighted toward the
        // ends where the conductance changes fastest.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            if (ph == RANDOM_PHASES - 1)
                idle_on = 1'b0;

            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IDX_W'($urandom_range(int'(REG_COEF_THREE) + 1,
                                                    (1 << CFG_IDX_W) - 1)), $urandom);
            case ($urandom_range(0, 5))
                0:       coef = CFG_DATA_W'(1);
                1:       coef = CFG_DATA_W'({OHMS_W{1'b1}});
                2:       coef = CFG_DATA_W'(1_000_000);
                3:       coef = CFG_DATA_W'($urandom_range(1, 1000));
                default: coef = CFG_DATA_W'($urandom_range(1, 1_000_000));
            endcase
            coef[CFG_DATA_W-1:OHMS_W] = $urandom;
            write_reg(REG_SERIES_OHMS, coef);
            for (int r = int'(REG_COEF_ZERO); r <= int'(REG_COEF_THREE); r++) begin
                case ($urandom_range(0, 7))
                    0:       coef = 32'h7FFF_FFFF;
                    1:       coef = 32'h8000_0000;
                    2:       coef = '0;
                    3:       coef = $urandom;
                    default: begin
                        coef = $urandom >> $urandom_range(4, 31);
                        if ($urandom_range(0, 1))
                            coef = -coef;
                    end
                endcase
                write_reg(CFG_IDX_W'(r), coef);
            end

            // The second phase carries the long receiver hold-off.
            if (ph == 1)
                pressure_go = 1'b1;

            for (int b = 0; b < BLOCKS_PER_PHASE; b++) begin
                center = $urandom_range(0, SAMPLE_MAX) >> $urandom_range(0, SAMPLE_W - 1);
                if ($urandom_range(0, 1))
                    center = SAMPLE_MAX - center;
                pick = $urandom_range(0, 7);
                if (pick == 0)
                    send_block(SHAPE_UNIFORM, 0, 0);
                else if (pick == 1)
                    send_block(SHAPE_FLAT, center, 0);
                else
                    send_block(SHAPE_JITTER, center, $urandom_range(0, 3000));
            end
        end

        settle();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* fsr_block_average_weight.f */
rtl/fsr_baw_pkg.sv
rtl/fsr_block_average_weight.sv
dv/fsr_baw_checker.sv
dv/fsr_block_average_weight_tb.sv
